### sv/qypr_pkg.sv
// Shared constants, types and arithmetic helpers for the quaternion angle pipeline.
`default_nettype none

package qypr_pkg;

    localparam int QUAT_FRACTION_BITS  = 14;
    localparam int ANGLE_FRACTION_BITS = 7;
    localparam int Z_FRAC              = 20;
    localparam int CORDIC_N            = 24;
    localparam int SQ_N                = 32;
    localparam int S_W                 = 32;   // width of a sum of two squares
    localparam int C_W                 = 37;   // CORDIC x / y width
    localparam int Z_W                 = 31;   // CORDIC angle width
    localparam int Z_SHIFT             = Z_FRAC - ANGLE_FRACTION_BITS;

    localparam logic signed [Z_W-1:0] Z_HALF = 31'sd188743680;  // 180 deg
    localparam logic signed [31:0] YAW_LIM   = 32'sd180 <<< ANGLE_FRACTION_BITS;
    localparam logic signed [31:0] TILT_LIM  = 32'sd90 <<< ANGLE_FRACTION_BITS;

    localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_N-1] = '{
        31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
        31'sd3750058,  31'sd1876857,  31'sd938658,   31'sd469357,
        31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
        31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
        31'sd917,      31'sd458,      31'sd229,      31'sd115,
        31'sd57,       31'sd29,       31'sd14,       31'sd7
    };

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } t_sqr;

    typedef struct packed {
        logic [S_W-1:0]      sp;
        logic [S_W-1:0]      sr;
        t_sqr                qp;
        t_sqr                qr;
        logic signed [15:0]  gx;
        logic signed [15:0]  gy;
        logic signed [15:0]  gz;
        logic signed [35:0]  num;
        logic signed [35:0]  den;
    } t_isq;

    typedef struct packed {
        logic signed [C_W-1:0] x;
        logic signed [C_W-1:0] y;
        logic signed [Z_W-1:0] z;
        logic                  nz;
    } t_cvec;

    typedef struct packed {
        t_cvec [2:0]        ch;   // 0 yaw, 1 pitch, 2 roll
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } t_cor;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767) begin
            r = 16'sd32767;
        end else if (v < -36'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

    // One digit of the restoring square root: two radicand bits in, one root bit out.
    function automatic t_sqr isq_step(input t_sqr a, input logic [1:0] bits);
        t_sqr r;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        rem_sh = {a.rem, bits};
        trial  = {2'b00, a.root, 2'b01};
        if (rem_sh >= trial) begin
            r.rem  = 34'(rem_sh - trial);
            r.root = {a.root[30:0], 1'b1};
        end else begin
            r.rem  = 34'(rem_sh);
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_cvec cor_prep(input logic signed [C_W-1:0] y,
                                       input logic signed [C_W-1:0] x);
        t_cvec r;
        r.nz = (x != '0) || (y != '0);
        if (x < 0) begin
            r.x = -x;
            r.y = -y;
            r.z = (y >= 0) ? Z_HALF : -Z_HALF;
        end else begin
            r.x = x;
            r.y = y;
            r.z = '0;
        end
        return r;
    endfunction

    function automatic t_cvec cor_step(input t_cvec a, input int i);
        t_cvec r;
        r = a;
        if (a.y >= 0) begin
            r.x = a.x + (a.y >>> i);
            r.y = a.y - (a.x >>> i);
            r.z = a.z + ATAN_TAB[i];
        end else begin
            r.x = a.x - (a.y >>> i);
            r.y = a.y + (a.x >>> i);
            r.z = a.z - ATAN_TAB[i];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_angle(input t_cvec c,
                                                    input logic signed [31:0] lim);
        logic signed [31:0] a;
        a = (32'(c.z) + (32'sd1 <<< (Z_SHIFT - 1))) >>> Z_SHIFT;
        if (!c.nz) begin
            a = '0;
        end else if (a > lim) begin
            a = lim;
        end else if (a < -lim) begin
            a = -lim;
        end
        return 16'(a);
    endfunction

endpackage

`default_nettype wire

### sv/quaternion_to_yaw_pitch_roll.sv
// Quaternion to gravity vector and yaw / pitch / roll, fully pipelined.
`default_nettype none

// One Q14 quaternion enters per beat and one result leaves per beat. The pipeline runs:
// one stage of sixteen-bit products, one stage that forms the saturated gravity vector
// and the yaw arguments, one stage of gravity squares, one stage of sums, 32 square-root
// digit stages (one root bit each), one quadrant stage, 24 CORDIC vectoring stages (three
// rotators side by side for yaw, pitch and roll) and a rounding / output register. The
// whole pipe advances as one: an output stall holds every stage, and the input stall
// is raised only while a finished result waits and the output is stalled. Angles come
// out in 1/128 degree; yaw is limited to +-180 degrees, pitch and roll to +-90.
// A zero atan2 vector gives angle 0; a zero root with a nonzero numerator gives +-90.
module quaternion_to_yaw_pitch_roll
    import qypr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_gravity_x,
    output logic signed [15:0]      o_gravity_y,
    output logic signed [15:0]      o_gravity_z,
    output logic signed [15:0]      o_yaw_angle,
    output logic signed [14:0]      o_pitch_angle,
    output logic signed [14:0]      o_roll_angle
);

    // Pipe enable: hold everything while the output beat is stalled.
    logic w_en;
    logic r_out_v;
    assign w_en    = !(r_out_v && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_v;

    // ---- stage 1: products ------------------------------------------------
    logic r_v1;
    logic signed [31:0] r_p_xz, r_p_wy, r_p_wx, r_p_yz, r_p_ww;
    logic signed [31:0] r_p_xx, r_p_yy, r_p_zz, r_p_xy, r_p_wz;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_xz <= 32'(i_quat_x) * 32'(i_quat_z);
            r_p_wy <= 32'(i_quat_w) * 32'(i_quat_y);
            r_p_wx <= 32'(i_quat_w) * 32'(i_quat_x);
            r_p_yz <= 32'(i_quat_y) * 32'(i_quat_z);
            r_p_ww <= 32'(i_quat_w) * 32'(i_quat_w);
            r_p_xx <= 32'(i_quat_x) * 32'(i_quat_x);
            r_p_yy <= 32'(i_quat_y) * 32'(i_quat_y);
            r_p_zz <= 32'(i_quat_z) * 32'(i_quat_z);
            r_p_xy <= 32'(i_quat_x) * 32'(i_quat_y);
            r_p_wz <= 32'(i_quat_w) * 32'(i_quat_z);
        end
    end

    // ---- stage 2: gravity vector and yaw arguments ----------------------------
    logic r_v2;
    logic signed [15:0] r_gx2, r_gy2, r_gz2;
    logic signed [35:0] r_num2, r_den2;
    logic signed [35:0] n_gx_raw, n_gy_raw, n_gz_raw, n_num, n_den;

    always_comb begin
        n_gx_raw = 36'(r_p_xz) - 36'(r_p_wy);
        n_gy_raw = 36'(r_p_wx) + 36'(r_p_yz);
        n_gz_raw = 36'(r_p_ww) - 36'(r_p_xx) - 36'(r_p_yy) + 36'(r_p_zz);
        n_num    = (36'(r_p_xy) - 36'(r_p_wz)) <<< 1;
        n_den    = ((36'(r_p_ww) + 36'(r_p_xx)) <<< 1)
                   - (36'sd1 <<< (2 * QUAT_FRACTION_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx2  <= sat16((n_gx_raw + (36'sd1 <<< (QUAT_FRACTION_BITS - 2)))
                            >>> (QUAT_FRACTION_BITS - 1));
            r_gy2  <= sat16((n_gy_raw + (36'sd1 <<< (QUAT_FRACTION_BITS - 2)))
                            >>> (QUAT_FRACTION_BITS - 1));
            r_gz2  <= sat16((n_gz_raw + (36'sd1 <<< (QUAT_FRACTION_BITS - 1)))
                            >>> QUAT_FRACTION_BITS);
            r_num2 <= n_num;
            r_den2 <= n_den;
        end
    end

    // ---- stage 3: gravity squares -------------------------------------------
    logic r_v3;
    logic signed [31:0] r_sq_x, r_sq_y, r_sq_z;
    logic signed [15:0] r_gx3, r_gy3, r_gz3;
    logic signed [35:0] r_num3, r_den3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_x <= 32'(r_gx2) * 32'(r_gx2);
            r_sq_y <= 32'(r_gy2) * 32'(r_gy2);
            r_sq_z <= 32'(r_gz2) * 32'(r_gz2);
            r_gx3  <= r_gx2;
            r_gy3  <= r_gy2;
            r_gz3  <= r_gz2;
            r_num3 <= r_num2;
            r_den3 <= r_den2;
        end
    end

    // ---- stage 4 and square root digit stages ------------------------------------
    // Root of (s * 2^32): the upper 16 digits take bits of s, the lower 16 take zeros.
    logic r_sq_v [0:SQ_N];
    t_isq r_sq   [0:SQ_N];
    t_isq n_sq   [1:SQ_N];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0].sp  <= S_W'($unsigned(r_sq_y)) + S_W'($unsigned(r_sq_z));
            r_sq[0].sr  <= S_W'($unsigned(r_sq_x)) + S_W'($unsigned(r_sq_z));
            r_sq[0].qp  <= '0;
            r_sq[0].qr  <= '0;
            r_sq[0].gx  <= r_gx3;
            r_sq[0].gy  <= r_gy3;
            r_sq[0].gz  <= r_gz3;
            r_sq[0].num <= r_num3;
            r_sq[0].den <= r_den3;
        end
    end

    for (genvar k = 0; k < SQ_N; k++) begin : g_isq
        logic [1:0] w_pbits;
        logic [1:0] w_rbits;

        if (k < SQ_N / 2) begin : g_hi
            assign w_pbits = r_sq[k].sp[S_W-1-2*k -: 2];
            assign w_rbits = r_sq[k].sr[S_W-1-2*k -: 2];
        end else begin : g_lo
            assign w_pbits = 2'b00;
            assign w_rbits = 2'b00;
        end

        always_comb begin
            n_sq[k+1]    = r_sq[k];
            n_sq[k+1].qp = isq_step(r_sq[k].qp, w_pbits);
            n_sq[k+1].qr = isq_step(r_sq[k].qr, w_rbits);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k+1] <= n_sq[k+1];
            end
        end
    end

    // ---- quadrant stage and CORDIC vectoring stages --------------------------------
    logic r_cr_v [0:CORDIC_N];
    t_cor r_cr   [0:CORDIC_N];
    t_cor n_cr   [0:CORDIC_N];

    always_comb begin
        n_cr[0].ch[0] = cor_prep(C_W'(r_sq[SQ_N].num), C_W'(r_sq[SQ_N].den));
        n_cr[0].ch[1] = cor_prep(C_W'(r_sq[SQ_N].gx) <<< 16,
                                 C_W'(r_sq[SQ_N].qp.root));
        n_cr[0].ch[2] = cor_prep(C_W'(r_sq[SQ_N].gy) <<< 16,
                                 C_W'(r_sq[SQ_N].qr.root));
        n_cr[0].gx    = r_sq[SQ_N].gx;
        n_cr[0].gy    = r_sq[SQ_N].gy;
        n_cr[0].gz    = r_sq[SQ_N].gz;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cr[0] <= n_cr[0];
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++) begin : g_cor
        always_comb begin
            n_cr[i+1] = r_cr[i];
            for (int j = 0; j < 3; j++) begin
                n_cr[i+1].ch[j] = cor_step(r_cr[i].ch[j], i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cr[i+1] <= n_cr[i+1];
            end
        end
    end

    // ---- output register: round to 1/128 degree and limit ---------------------------
    logic signed [15:0] n_pitch16, n_roll16;
    assign n_pitch16 = to_angle(r_cr[CORDIC_N].ch[1], TILT_LIM);
    assign n_roll16  = to_angle(r_cr[CORDIC_N].ch[2], TILT_LIM);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_gravity_x   <= r_cr[CORDIC_N].gx;
            o_gravity_y   <= r_cr[CORDIC_N].gy;
            o_gravity_z   <= r_cr[CORDIC_N].gz;
            o_yaw_angle   <= to_angle(r_cr[CORDIC_N].ch[0], YAW_LIM);
            o_pitch_angle <= n_pitch16[14:0];
            o_roll_angle  <= n_roll16[14:0];
        end
    end

    // ---- valid bits travel with the data -------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= SQ_N; k++) begin
                r_sq_v[k] <= 1'b0;
            end
            for (int i = 0; i <= CORDIC_N; i++) begin
                r_cr_v[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1      <= i_valid;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_sq_v[0] <= r_v3;
            for (int k = 0; k < SQ_N; k++) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
            r_cr_v[0] <= r_sq_v[SQ_N];
            for (int i = 0; i < CORDIC_N; i++) begin
                r_cr_v[i+1] <= r_cr_v[i];
            end
            r_out_v <= r_cr_v[CORDIC_N];
        end
    end

endmodule

`default_nettype wire
